// ----- rtl/pwc_pkg.sv -----
// package for the packet watchlist counter
// holds payload structs, table sizes, command codes and the hash step
// no dependencies

package pwc_pkg;

  localparam int TableEntries = 64;
  localparam int IdxW = $clog2(TableEntries);
  localparam int CntW = $clog2(TableEntries + 1);
  localparam int HashBytes = 64;
  localparam logic [31:0] HashSeed = 32'd5381;
  localparam logic [31:0] CountMax = 32'hffff_ffff;

  typedef enum logic [2:0] {
    CMD_ADD_SRC  = 3'd0,
    CMD_ADD_HASH = 3'd1,
    CMD_ADD_PORT = 3'd2,
    CMD_DEL_SRC  = 3'd3,
    CMD_DEL_HASH = 3'd4,
    CMD_DEL_PORT = 3'd5,
    CMD_NOP6     = 3'd6,
    CMD_NOP7     = 3'd7
  } cmd_t;

  // table select
  typedef enum logic [1:0] {
    TBL_SRC  = 2'd0,
    TBL_PORT = 2'd1,
    TBL_HASH = 2'd2
  } tbl_t;

  // table operation: idle scans and reports nothing
  typedef enum logic [1:0] {
    OP_BUMP = 2'd0,
    OP_ADD  = 2'd1,
    OP_DEL  = 2'd2,
    OP_IDLE = 2'd3
  } op_t;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic        last_byte;
    logic [15:0] secret_word;
    logic [2:0]  command_code;
    logic [31:0] command_data;
    logic [31:0] source_address;
    logic [15:0] dest_port;
  } in_beat_t;

  typedef struct packed {
    logic        was_command;
    logic        table_full;
    logic        source_hit;
    logic        port_hit;
    logic        hash_hit;
    logic [31:0] source_count;
    logic [31:0] port_count;
    logic [31:0] hash_count;
    logic [31:0] packet_total;
  } out_beat_t;

  // h*33 + b as shift and add
  function automatic logic [31:0] djb2_step(input logic [31:0] h, input logic [7:0] b);
    djb2_step = {h[26:0], 5'd0} + h + {24'd0, b};
  endfunction

endpackage

// ----- rtl/pwc_ram.sv -----
// generic single port ram with registered read
// no dependencies

module pwc_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/pwc_table.sv -----
// one watch table: key ram, count ram, valid flops and scan sequencer
// walks entries one per cycle to find the first match and first free slot
// depends on pwc_pkg and pwc_ram

module pwc_table (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,   // pulse: begin a scan
  input  pwc_pkg::op_t        op,
  input  logic [31:0]         key,
  output logic                done,    // pulse when finished
  output logic                hit,
  output logic                full,
  output logic [31:0]         count
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_ACT, S_RD, S_WR} st_t;

  st_t                        st;
  logic [pwc_pkg::CntW-1:0]   idx;
  logic [pwc_pkg::IdxW-1:0]   pend;      // entry whose read is in flight
  logic [pwc_pkg::IdxW-1:0]   hit_idx;
  logic [pwc_pkg::IdxW-1:0]   free_idx;
  logic                       found;
  logic                       have_free;
  logic                       pend_ok;
  logic [pwc_pkg::TableEntries-1:0] valid;

  logic                       k_we;
  logic                       c_we;
  logic [pwc_pkg::IdxW-1:0]   addr;
  logic [31:0]                k_rd;
  logic [31:0]                c_rd;
  logic [31:0]                c_wd;

  pwc_ram #(.Width(32), .Depth(pwc_pkg::TableEntries)) u_keys (
    .clk(clk), .we(k_we), .addr(addr), .wdata(key), .rdata(k_rd)
  );
  pwc_ram #(.Width(32), .Depth(pwc_pkg::TableEntries)) u_counts (
    .clk(clk), .we(c_we), .addr(addr), .wdata(c_wd), .rdata(c_rd)
  );

  // the shared compare: key read last cycle against the search key
  logic match;
  assign match = pend_ok && valid[pend] && (k_rd == key) && !found;

  always_comb begin
    k_we = 1'b0;
    c_we = 1'b0;
    c_wd = (c_rd == pwc_pkg::CountMax) ? c_rd : c_rd + 32'd1;
    addr = idx[pwc_pkg::IdxW-1:0];
    unique case (st)
      S_ACT: begin
        addr = found ? hit_idx : free_idx;
        if (op == pwc_pkg::OP_ADD && (found || have_free)) begin
          k_we = !found;
          c_we = 1'b1;
          c_wd = '0;
        end
      end
      S_RD:  addr = hit_idx;
      S_WR: begin
        addr = hit_idx;
        c_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      st      <= S_IDLE;
      valid   <= '0;
      pend_ok <= 1'b0;
      idx     <= '0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (start) begin
            st        <= S_SCAN;
            idx       <= '0;
            pend_ok   <= 1'b0;
            found     <= 1'b0;
            have_free <= 1'b0;
          end
        end
        S_SCAN, S_LAST: begin
          if (match) begin
            found   <= 1'b1;
            hit_idx <= pend;
          end
          if (st == S_SCAN) begin
            if (!valid[idx[pwc_pkg::IdxW-1:0]] && !have_free) begin
              have_free <= 1'b1;
              free_idx  <= idx[pwc_pkg::IdxW-1:0];
            end
            pend    <= idx[pwc_pkg::IdxW-1:0];
            pend_ok <= 1'b1;
            idx     <= idx + 1'b1;
            if (idx == pwc_pkg::CntW'(pwc_pkg::TableEntries - 1)) begin
              st <= S_LAST;
            end
          end else begin
            pend_ok <= 1'b0;
            st      <= S_ACT;
          end
        end
        S_ACT: begin
          hit   <= found;
          full  <= 1'b0;
          count <= '0;
          unique case (op)
            pwc_pkg::OP_ADD: begin
              hit <= 1'b0;
              if (!found && !have_free) begin
                full <= 1'b1;
              end else if (!found) begin
                valid[free_idx] <= 1'b1;
              end
              done <= 1'b1;
              st   <= S_IDLE;
            end
            pwc_pkg::OP_DEL: begin
              hit <= 1'b0;
              if (found) begin
                valid[hit_idx] <= 1'b0;
              end
              done <= 1'b1;
              st   <= S_IDLE;
            end
            pwc_pkg::OP_IDLE: begin
              hit  <= 1'b0;
              done <= 1'b1;
              st   <= S_IDLE;
            end
            default: begin
              if (found) begin
                st <= S_RD;
              end else begin
                done <= 1'b1;
                st   <= S_IDLE;
              end
            end
          endcase
        end
        S_RD: st <= S_WR;
        S_WR: begin
          count <= c_wd;
          done  <= 1'b1;
          st    <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held two cycles");
  a_full_only_add: assert property (@(posedge clk) disable iff (rst)
    (done && full) |-> (op == pwc_pkg::OP_ADD))
    else $error("full flagged outside add");
  a_hit_not_full: assert property (@(posedge clk) disable iff (rst)
    done |-> !(hit && full))
    else $error("hit and full together");
`endif

endmodule

// ----- rtl/packet_watchlist_counter_core.sv -----
// top level of the packet watchlist counter
// byte hashing, command decode, three table sequencers and the result register
// depends on pwc_pkg, pwc_table, pwc_ram
//
// channel  | direction | handshake           | payload
// in       | input     | in_valid/in_ready   | pwc_pkg::in_beat_t
// out      | output    | out_valid/out_ready | pwc_pkg::out_beat_t
// cfg      | input     | cfg_valid/cfg_ready | 16 bit secret
//
// a non-final byte never stalls the input: the hash update is registered at accept
// after a final byte the three tables scan in parallel, one entry a cycle through their
// key ram read ports; out_valid rises once all three are done, and a hit on a regular
// packet adds a count read and a count write after its table's scan
// the result sits in an output register; in_ready drops once a final byte is taken and returns
// the cycle after the result beat is taken
// synchronous reset clears valid flops, counters and secret and reloads the hash seed; rams need no clear

module packet_watchlist_counter_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pwc_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pwc_pkg::out_beat_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} st_t;

  st_t                st;
  logic [15:0]        secret;
  logic [31:0]        running_hash;
  logic [7:0]         byte_index;
  logic [31:0]        packets_seen;
  logic [31:0]        hash_key;      // hash of the finished packet, or the command key for a command
  logic               is_cmd;
  logic               start;
  pwc_pkg::op_t       op_src;
  pwc_pkg::op_t       op_port;
  pwc_pkg::op_t       op_hash;
  logic [31:0]        src_key;
  logic [15:0]        port_key;
  logic [2:0]         pend;          // tables still busy

  logic       d_src, d_port, d_hash;
  logic       h_src, h_port, h_hash;
  logic       f_src, f_port, f_hash;
  logic [31:0] c_src, c_port, c_hash;

  logic in_fire;
  assign in_fire   = in_valid && in_ready;
  assign in_ready  = (st == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (st == S_OUT);

  // running hash including the current byte, if it lies within the first HashBytes bytes
  logic [31:0] hash_now;
  assign hash_now = (byte_index < 8'(pwc_pkg::HashBytes))
                  ? pwc_pkg::djb2_step(running_hash, in_data.byte_value) : running_hash;

  pwc_table u_src (
    .clk(clk), .rst(rst), .start(start), .op(op_src), .key(src_key),
    .done(d_src), .hit(h_src), .full(f_src), .count(c_src)
  );
  // port keys are held zero extended
  pwc_table u_port (
    .clk(clk), .rst(rst), .start(start), .op(op_port), .key({16'd0, port_key}),
    .done(d_port), .hit(h_port), .full(f_port), .count(c_port)
  );
  pwc_table u_hash (
    .clk(clk), .rst(rst), .start(start), .op(op_hash), .key(hash_key),
    .done(d_hash), .hit(h_hash), .full(f_hash), .count(c_hash)
  );

  always_ff @(posedge clk) begin
    start <= 1'b0;
    if (rst) begin
      st           <= S_IDLE;
      secret       <= '0;
      running_hash <= pwc_pkg::HashSeed;
      byte_index   <= '0;
      packets_seen <= '0;
      pend         <= '0;
    end else begin
      if (cfg_valid) begin
        secret <= cfg_data;
      end
      unique case (st)
        S_IDLE: begin
          if (in_fire) begin
            if (!in_data.last_byte) begin
              running_hash <= hash_now;
              if (byte_index < 8'(pwc_pkg::HashBytes)) begin
                byte_index <= byte_index + 8'd1;
              end
            end else begin
              running_hash <= pwc_pkg::HashSeed;
              byte_index   <= '0;
              packets_seen <= packets_seen + 32'd1;
              hash_key     <= hash_now;
              is_cmd       <= (in_data.secret_word == secret);
              start        <= 1'b1;
              pend         <= 3'b111;
              st           <= S_RUN;
              // tables the command does not name scan idle
              if (in_data.secret_word == secret) begin
                src_key  <= in_data.command_data;
                hash_key <= in_data.command_data;
                port_key <= in_data.command_data[31:16];
                op_src   <= pwc_pkg::OP_IDLE;
                op_port  <= pwc_pkg::OP_IDLE;
                op_hash  <= pwc_pkg::OP_IDLE;
                case (pwc_pkg::cmd_t'(in_data.command_code))
                  pwc_pkg::CMD_ADD_SRC:  op_src  <= pwc_pkg::OP_ADD;
                  pwc_pkg::CMD_ADD_HASH: op_hash <= pwc_pkg::OP_ADD;
                  pwc_pkg::CMD_ADD_PORT: op_port <= pwc_pkg::OP_ADD;
                  pwc_pkg::CMD_DEL_SRC:  op_src  <= pwc_pkg::OP_DEL;
                  pwc_pkg::CMD_DEL_HASH: op_hash <= pwc_pkg::OP_DEL;
                  pwc_pkg::CMD_DEL_PORT: op_port <= pwc_pkg::OP_DEL;
                  default: ;
                endcase
              end else begin
                src_key  <= in_data.source_address;
                port_key <= in_data.dest_port;
                op_src   <= pwc_pkg::OP_BUMP;
                op_port  <= pwc_pkg::OP_BUMP;
                op_hash  <= pwc_pkg::OP_BUMP;
              end
            end
          end
        end
        S_RUN: begin
          pend <= pend & ~{d_hash, d_port, d_src};
          if ((pend & ~{d_hash, d_port, d_src}) == 3'b000) begin
            out_data.was_command  <= is_cmd;
            out_data.table_full   <= is_cmd && (f_src || f_port || f_hash);
            out_data.source_hit   <= !is_cmd && h_src;
            out_data.port_hit     <= !is_cmd && h_port;
            out_data.hash_hit     <= !is_cmd && h_hash;
            out_data.source_count <= is_cmd ? 32'd0 : c_src;
            out_data.port_count   <= is_cmd ? 32'd0 : c_port;
            out_data.hash_count   <= is_cmd ? 32'd0 : c_hash;
            out_data.packet_total <= packets_seen;
            st <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_cmd_no_hits: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.was_command) |-> !(out_data.source_hit || out_data.port_hit
      || out_data.hash_hit))
    else $error("command beat reports hits");
  a_full_cmd: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.table_full) |-> out_data.was_command)
    else $error("table full on a regular beat");
  a_start_from_last: assert property (@(posedge clk) disable iff (rst)
    start |-> $past(in_fire && in_data.last_byte))
    else $error("scan started without a final byte");
  a_byte_index_cap: assert property (@(posedge clk) disable iff (rst)
    byte_index <= 8'(pwc_pkg::HashBytes))
    else $error("byte index past hash length");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// self-checking testbench for packet_watchlist_counter_core
// drives packet bytes and secret writes, predicts results with its own table model
// depends on pwc_pkg and the core rtl

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  pwc_pkg::in_beat_t in_data;
  pwc_pkg::out_beat_t out_data;
  logic [15:0] cfg_data;

  packet_watchlist_counter_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // watch table shadow state
  logic [31:0] src_key_m [pwc_pkg::TableEntries];
  logic [31:0] src_cnt_m [pwc_pkg::TableEntries];
  logic        src_vld_m [pwc_pkg::TableEntries];
  logic [15:0] port_key_m [pwc_pkg::TableEntries];
  logic [31:0] port_cnt_m [pwc_pkg::TableEntries];
  logic        port_vld_m [pwc_pkg::TableEntries];
  logic [31:0] hash_key_m [pwc_pkg::TableEntries];
  logic [31:0] hash_cnt_m [pwc_pkg::TableEntries];
  logic        hash_vld_m [pwc_pkg::TableEntries];
  logic [31:0] hash_acc, pkt_seen;
  int          byte_pos;
  logic [15:0] secret_m;

  pwc_pkg::out_beat_t pending_results[$];
  int errors, mismatches, results_seen, beats_sent;
  bit quiet_tail;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int find_entry(int tbl, logic [31:0] key);
    for (int i = 0; i < pwc_pkg::TableEntries; i++) begin
      if (tbl == pwc_pkg::TBL_SRC && src_vld_m[i] && src_key_m[i] == key) return i;
      if (tbl == pwc_pkg::TBL_PORT && port_vld_m[i] && {16'd0, port_key_m[i]} == key)
        return i;
      if (tbl == pwc_pkg::TBL_HASH && hash_vld_m[i] && hash_key_m[i] == key) return i;
    end
    return -1;
  endfunction

  // add key or reset its count; returns 1 when the table is full
  function automatic logic add_entry(int tbl, logic [31:0] key);
    int i;
    i = find_entry(tbl, key);
    if (i < 0) begin
      for (i = 0; i < pwc_pkg::TableEntries; i++) begin
        if (tbl == pwc_pkg::TBL_SRC && !src_vld_m[i]) break;
        if (tbl == pwc_pkg::TBL_PORT && !port_vld_m[i]) break;
        if (tbl == pwc_pkg::TBL_HASH && !hash_vld_m[i]) break;
      end
      if (i >= pwc_pkg::TableEntries) return 1'b1;
      case (tbl)
        pwc_pkg::TBL_SRC: begin src_key_m[i] = key; src_vld_m[i] = 1; end
        pwc_pkg::TBL_PORT: begin port_key_m[i] = key[15:0]; port_vld_m[i] = 1; end
        default: begin hash_key_m[i] = key; hash_vld_m[i] = 1; end
      endcase
    end
    case (tbl)
      pwc_pkg::TBL_SRC: src_cnt_m[i] = 0;
      pwc_pkg::TBL_PORT: port_cnt_m[i] = 0;
      default: hash_cnt_m[i] = 0;
    endcase
    return 1'b0;
  endfunction

  function automatic void drop_entry(int tbl, logic [31:0] key);
    int i;
    i = find_entry(tbl, key);
    if (i < 0) return;
    case (tbl)
      pwc_pkg::TBL_SRC: src_vld_m[i] = 0;
      pwc_pkg::TBL_PORT: port_vld_m[i] = 0;
      default: hash_vld_m[i] = 0;
    endcase
  endfunction

  // saturating bump, returns the new count; hit flag via ref
  function automatic logic [31:0] bump_entry(int tbl, logic [31:0] key, ref logic hit);
    int i;
    logic [31:0] c;
    i = find_entry(tbl, key);
    hit = (i >= 0);
    if (i < 0) return 32'd0;
    case (tbl)
      pwc_pkg::TBL_SRC: begin
        if (src_cnt_m[i] != pwc_pkg::CountMax) src_cnt_m[i]++;
        c = src_cnt_m[i];
      end
      pwc_pkg::TBL_PORT: begin
        if (port_cnt_m[i] != pwc_pkg::CountMax) port_cnt_m[i]++;
        c = port_cnt_m[i];
      end
      default: begin
        if (hash_cnt_m[i] != pwc_pkg::CountMax) hash_cnt_m[i]++;
        c = hash_cnt_m[i];
      end
    endcase
    return c;
  endfunction

  // per-byte prediction; queues a result on the last byte
  function automatic void predict_byte(pwc_pkg::in_beat_t b);
    pwc_pkg::out_beat_t r;
    logic h;
    logic [31:0] pkt_hash;
    if (byte_pos < pwc_pkg::HashBytes) begin
      hash_acc = hash_acc * 33 + b.byte_value;
      byte_pos++;
    end
    if (!b.last_byte) return;
    pkt_hash = hash_acc;
    hash_acc = pwc_pkg::HashSeed;
    byte_pos = 0;
    pkt_seen++;
    r = '0;
    if (b.secret_word == secret_m) begin
      r.was_command = 1;
      case (pwc_pkg::cmd_t'(b.command_code))
        pwc_pkg::CMD_ADD_SRC: r.table_full = add_entry(pwc_pkg::TBL_SRC, b.command_data);
        pwc_pkg::CMD_ADD_HASH: r.table_full = add_entry(pwc_pkg::TBL_HASH, b.command_data);
        pwc_pkg::CMD_ADD_PORT:
          r.table_full = add_entry(pwc_pkg::TBL_PORT, {16'd0, b.command_data[31:16]});
        pwc_pkg::CMD_DEL_SRC: drop_entry(pwc_pkg::TBL_SRC, b.command_data);
        pwc_pkg::CMD_DEL_HASH: drop_entry(pwc_pkg::TBL_HASH, b.command_data);
        pwc_pkg::CMD_DEL_PORT: drop_entry(pwc_pkg::TBL_PORT, {16'd0, b.command_data[31:16]});
        default: ;
      endcase
    end else begin
      r.source_count = bump_entry(pwc_pkg::TBL_SRC, b.source_address, h);
      r.source_hit = h;
      r.port_count = bump_entry(pwc_pkg::TBL_PORT, {16'd0, b.dest_port}, h);
      r.port_hit = h;
      r.hash_count = bump_entry(pwc_pkg::TBL_HASH, pkt_hash, h);
      r.hash_hit = h;
    end
    r.packet_total = pkt_seen;
    pending_results.push_back(r);
  endfunction

  // random idle gap before about one beat in four, none in the quiet tail
  task automatic idle_gap();
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  // entered and left at a falling edge; valid stays up until replaced or dropped
  task automatic send_beat(pwc_pkg::in_beat_t b);
    idle_gap();
    in_data <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_byte(b);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_secret(logic [15:0] v);
    cfg_data <= v;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    secret_m = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // one packet: nbytes bytes, trailer fields on the last one
  task automatic send_packet(int nbytes, logic [15:0] sec, logic [2:0] code,
                             logic [31:0] data, logic [31:0] src, logic [15:0] port,
                             bit fixed_body = 0);
    pwc_pkg::in_beat_t b;
    for (int i = 0; i < nbytes; i++) begin
      b = '0;
      b.byte_value = fixed_body ? 8'(i) : 8'($urandom);
      if (i == nbytes - 1) begin
        b.last_byte = 1;
        b.secret_word = sec;
        b.command_code = code;
        b.command_data = data;
        b.source_address = src;
        b.dest_port = port;
      end else begin
        // junk trailer fields on inner bytes must be ignored
        b.secret_word = 16'($urandom);
        b.command_code = 3'($urandom);
        b.command_data = $urandom;
        b.source_address = $urandom;
        b.dest_port = 16'($urandom);
      end
      send_beat(b);
    end
  endtask

  // result sink: random stalls
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (!quiet_tail && $urandom_range(0, 15) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_ready <= 1;
      end else begin
        out_ready <= quiet_tail ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  // compare against oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %p", out_data);
      end else begin
        pwc_pkg::out_beat_t e;
        e = pending_results.pop_front();
        if (e !== out_data) begin
          errors++;
          if (mismatches++ < 10) $display("mismatch exp %p got %p", e, out_data);
        end
      end
    end
  end

  // directed rows: packet shape and trailer, with fixed expected results where obvious
  typedef struct {
    int           nbytes;
    logic [15:0]  sec;
    pwc_pkg::cmd_t code;
    logic [31:0]  data;
    logic [31:0]  src;
    logic [15:0]  port;
    bit           exp_cmd;    // plain command beat expected, no full flag
    logic [31:0]  exp_total;
  } pkt_row_t;

  pkt_row_t rows[$];
  logic [31:0] known_keys[$];

  initial begin
    in_valid = 0; cfg_valid = 0; in_data = '0; cfg_data = '0;
    rst = 1; quiet_tail = 0;
    errors = 0; mismatches = 0; results_seen = 0; beats_sent = 0;
    foreach (src_vld_m[i]) begin src_vld_m[i] = 0; port_vld_m[i] = 0; hash_vld_m[i] = 0; end
    hash_acc = pwc_pkg::HashSeed; pkt_seen = 0; byte_pos = 0; secret_m = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed table: secret 0 after reset, adds, hits, deletes, extremes
    rows = '{
      '{1, 16'h0000, pwc_pkg::CMD_ADD_SRC, 32'hffff_ffff, 0, 0, 1, 1},
      '{1, 16'h0000, pwc_pkg::CMD_ADD_PORT, 32'hffff_0000, 0, 0, 1, 2},
      '{1, 16'h0000, pwc_pkg::CMD_ADD_PORT, 32'h0000_ffff, 0, 0, 1, 3},
      '{1, 16'h0000, pwc_pkg::CMD_ADD_SRC, 32'h0000_0000, 0, 0, 1, 4},
      '{1, 16'h0000, pwc_pkg::CMD_NOP6, 32'h1234_5678, 0, 0, 1, 5},
      '{1, 16'h0000, pwc_pkg::CMD_NOP7, 32'h1234_5678, 0, 0, 1, 6},
      '{3, 16'hffff, pwc_pkg::CMD_ADD_SRC, 0, 32'hffff_ffff, 16'hffff, 0, 0},
      '{3, 16'hffff, pwc_pkg::CMD_ADD_SRC, 0, 32'hffff_ffff, 16'h0000, 0, 0},
      '{100, 16'h0001, pwc_pkg::CMD_ADD_SRC, 0, 32'h0, 16'h0, 0, 0},
      '{1, 16'h0000, pwc_pkg::CMD_ADD_SRC, 32'hffff_ffff, 0, 0, 0, 0},
      '{2, 16'h8000, pwc_pkg::CMD_ADD_SRC, 0, 32'hffff_ffff, 16'hffff, 0, 0},
      '{1, 16'h0000, pwc_pkg::CMD_DEL_SRC, 32'hffff_ffff, 0, 0, 0, 0},
      '{1, 16'h0000, pwc_pkg::CMD_DEL_SRC, 32'hffff_ffff, 0, 0, 0, 0},
      '{1, 16'h0000, pwc_pkg::CMD_DEL_PORT, 32'hffff_0000, 0, 0, 0, 0},
      '{1, 16'h0000, pwc_pkg::CMD_DEL_HASH, 32'h0, 0, 0, 0, 0},
      '{2, 16'h7fff, pwc_pkg::CMD_ADD_SRC, 0, 32'hffff_ffff, 16'hffff, 0, 0}
    };
    foreach (rows[i]) begin
      send_packet(rows[i].nbytes, rows[i].sec, rows[i].code, rows[i].data,
                  rows[i].src, rows[i].port, 1);
      // after reset and for ignored codes the result is fixed
      if (rows[i].exp_cmd) begin
        pwc_pkg::out_beat_t e;
        e = '0;
        e.was_command = 1'b1;
        e.packet_total = rows[i].exp_total;
        pending_results[pending_results.size() - 1] = e;
      end
    end
    // hash table: add the hash of bytes 0..N-1 for a short and a long packet
    begin
      logic [31:0] h;
      h = pwc_pkg::HashSeed;
      for (int i = 0; i < 4; i++) h = h * 33 + 8'(i);
      send_packet(1, 16'h0, pwc_pkg::CMD_ADD_HASH, h, 0, 0);
      send_packet(4, 16'h5, pwc_pkg::CMD_ADD_HASH, 0, 1, 2, 1);
      send_packet(4, 16'h5, pwc_pkg::CMD_ADD_HASH, 0, 1, 2, 1);
      h = pwc_pkg::HashSeed;
      for (int i = 0; i < pwc_pkg::HashBytes; i++) h = h * 33 + 8'(i);
      send_packet(1, 16'h0, pwc_pkg::CMD_ADD_HASH, h, 0, 0);
      send_packet(90, 16'h5, pwc_pkg::CMD_ADD_HASH, 0, 1, 2, 1);
    end
    // fill the source table past its size, then empty those keys again
    for (int i = 0; i <= pwc_pkg::TableEntries; i++)
      send_packet(1, 16'h0, pwc_pkg::CMD_ADD_SRC, 32'h1000_0000 + 32'(i), 0, 0);
    for (int i = 0; i <= pwc_pkg::TableEntries; i++)
      send_packet(1, 16'h0, pwc_pkg::CMD_DEL_SRC, 32'h1000_0000 + 32'(i), 0, 0);
    wait_drained();

    // random phases under several secrets, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      write_secret(ph == 0 ? 16'hffff : ph == 1 ? 16'h0000 : 16'($urandom));
      if (ph == 4) quiet_tail = 1;
      known_keys.delete();
      while (beats_sent < 360 * (ph + 1) + 50) begin
        int n;
        logic [15:0] sec;
        logic [2:0] code;
        logic [31:0] data, src;
        logic [15:0] port;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 5);
        code = 3'($urandom);
        data = ($urandom_range(0, 2) == 0 && known_keys.size() > 0) ?
               known_keys[$urandom_range(0, known_keys.size() - 1)] : $urandom;
        if (known_keys.size() < 70 && code <= pwc_pkg::CMD_ADD_PORT) known_keys.push_back(data);
        src = ($urandom_range(0, 1) && known_keys.size() > 0) ?
              known_keys[$urandom_range(0, known_keys.size() - 1)] : $urandom;
        port = ($urandom_range(0, 1) && known_keys.size() > 0) ?
               known_keys[$urandom_range(0, known_keys.size() - 1)][31:16] : 16'($urandom);
        sec = ($urandom_range(0, 2) == 0) ? secret_m : 16'($urandom);
        // short fixed bodies so hashes repeat and hit
        if (n <= 2 && $urandom_range(0, 1)) begin
          send_packet(n, sec, code, data, src, port, 1);
        end else begin
          send_packet(n, sec, code, data, src, port);
        end
      end
      wait_drained();
    end

    repeat (100) @(negedge clk);
    $display("sent %0d bytes, checked %0d packet results across 6 secret settings",
             beats_sent, results_seen);
    $display("covered adds, deletes, full tables, hits, ignored codes and long packets");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d errors, %0d left over", errors, pending_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/pwc_pkg.sv
rtl/pwc_ram.sv
rtl/pwc_table.sv
rtl/packet_watchlist_counter_core.sv
tb/sv/tb.sv
